@@ src/slex_pkg.sv @@
// Shared types, token kinds, scanner modes and character tables for the source lexer.
package slex_pkg;

  localparam int unsigned MaxKeywordLenDef = 6;
  localparam int unsigned MaxNestDef       = 255;
  localparam int unsigned NestW            = 16;
  localparam int unsigned QueueDepth       = 4;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_HASH    = 4'd1,
    M_LINE    = 4'd2,
    M_BLOCK   = 4'd3,
    M_BHASH   = 4'd4,
    M_UPPER   = 4'd5,
    M_LOWER   = 4'd6,
    M_INT     = 4'd7,
    M_FLOAT   = 4'd8,
    M_OP      = 4'd9,
    M_AT      = 4'd10,
    M_FOREIGN = 4'd11,
    M_STRING  = 4'd12,
    M_CHAR    = 4'd13
  } scan_mode_t;

  localparam logic [5:0] K_RETURN  = 6'd0;
  localparam logic [5:0] K_FUNC    = 6'd1;
  localparam logic [5:0] K_LET     = 6'd2;
  localparam logic [5:0] K_MUT     = 6'd3;
  localparam logic [5:0] K_KW_TYPE = 6'd4;
  localparam logic [5:0] K_IF      = 6'd5;
  localparam logic [5:0] K_ELSEIF  = 6'd6;
  localparam logic [5:0] K_ELSE    = 6'd7;
  localparam logic [5:0] K_CAST    = 6'd8;
  localparam logic [5:0] K_DEFER   = 6'd9;
  localparam logic [5:0] K_WHILE   = 6'd10;
  localparam logic [5:0] K_STRUCT  = 6'd11;
  localparam logic [5:0] K_UNION   = 6'd12;
  localparam logic [5:0] K_ENUM    = 6'd13;
  localparam logic [5:0] K_UNSAFE  = 6'd14;
  localparam logic [5:0] K_COLON   = 6'd15;
  localparam logic [5:0] K_ADD     = 6'd16;
  localparam logic [5:0] K_SUB     = 6'd17;
  localparam logic [5:0] K_MUL     = 6'd18;
  localparam logic [5:0] K_DIV     = 6'd19;
  localparam logic [5:0] K_MOD     = 6'd20;
  localparam logic [5:0] K_POW     = 6'd21;
  localparam logic [5:0] K_ARROW   = 6'd22;
  localparam logic [5:0] K_EQ      = 6'd23;
  localparam logic [5:0] K_NOT     = 6'd24;
  localparam logic [5:0] K_NE      = 6'd25;
  localparam logic [5:0] K_LT      = 6'd26;
  localparam logic [5:0] K_GT      = 6'd27;
  localparam logic [5:0] K_LE      = 6'd28;
  localparam logic [5:0] K_GE      = 6'd29;
  localparam logic [5:0] K_AND     = 6'd30;
  localparam logic [5:0] K_OR      = 6'd31;
  localparam logic [5:0] K_ASSIGN  = 6'd32;
  localparam logic [5:0] K_ADD_EQ  = 6'd33;
  localparam logic [5:0] K_SUB_EQ  = 6'd34;
  localparam logic [5:0] K_MUL_EQ  = 6'd35;
  localparam logic [5:0] K_DIV_EQ  = 6'd36;
  localparam logic [5:0] K_MOD_EQ  = 6'd37;
  localparam logic [5:0] K_POW_EQ  = 6'd38;
  localparam logic [5:0] K_BAR     = 6'd39;
  localparam logic [5:0] K_AMP     = 6'd40;
  localparam logic [5:0] K_DOT     = 6'd41;
  localparam logic [5:0] K_INT     = 6'd42;
  localparam logic [5:0] K_FLOAT   = 6'd43;
  localparam logic [5:0] K_STRING  = 6'd44;
  localparam logic [5:0] K_CHAR    = 6'd45;
  localparam logic [5:0] K_BOOL    = 6'd46;
  localparam logic [5:0] K_IDENT   = 6'd47;
  localparam logic [5:0] K_TYPE    = 6'd48;
  localparam logic [5:0] K_SEMI    = 6'd49;
  localparam logic [5:0] K_COMMA   = 6'd50;
  localparam logic [5:0] K_LPAREN  = 6'd51;
  localparam logic [5:0] K_RPAREN  = 6'd52;
  localparam logic [5:0] K_LBRACE  = 6'd53;
  localparam logic [5:0] K_RBRACE  = 6'd54;
  localparam logic [5:0] K_LBRACK  = 6'd55;
  localparam logic [5:0] K_RBRACK  = 6'd56;
  localparam logic [5:0] K_FOREIGN = 6'd57;
  localparam logic [5:0] K_EOF     = 6'd58;
  localparam logic [5:0] K_ERROR   = 6'd59;
  localparam logic [5:0] K_NONE    = 6'd63;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_OPEN_BLK = 3'd1;
  localparam logic [2:0] E_STRAY    = 3'd2;
  localparam logic [2:0] E_OPEN_STR = 3'd3;
  localparam logic [2:0] E_BAD_CHR  = 3'd4;
  localparam logic [2:0] E_BAD_FGN  = 3'd5;
  localparam logic [2:0] E_BAD_BYTE = 3'd6;
  localparam logic [2:0] E_NEST     = 3'd7;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic [2:0]  err;
    logic        last;
  } token_t;

  // Up to three results per byte, packed in order.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } group_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return b >= 8'h41 && b <= 8'h5A;
  endfunction
  function automatic logic is_lower(input logic [7:0] b);
    return b >= 8'h61 && b <= 8'h7A;
  endfunction
  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_word(input logic [7:0] b);
    return is_upper(b) || is_lower(b) || is_digit(b) || b == 8'h5F;
  endfunction

  function automatic logic [5:0] op_first(input logic [7:0] b);
    case (b)
      8'h2B:   return K_ADD;
      8'h2D:   return K_SUB;
      8'h2A:   return K_MUL;
      8'h2F:   return K_DIV;
      8'h25:   return K_MOD;
      8'h5E:   return K_POW;
      8'h3D:   return K_ASSIGN;
      8'h21:   return K_NOT;
      8'h3C:   return K_LT;
      8'h3E:   return K_GT;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] b);
    case (b)
      8'h3A:   return K_COLON;
      8'h3B:   return K_SEMI;
      8'h2C:   return K_COMMA;
      8'h2E:   return K_DOT;
      8'h26:   return K_AMP;
      8'h7C:   return K_BAR;
      8'h5B:   return K_LBRACK;
      8'h5D:   return K_RBRACK;
      8'h7B:   return K_LBRACE;
      8'h7D:   return K_RBRACE;
      8'h28:   return K_LPAREN;
      8'h29:   return K_RPAREN;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] pair_kind(input logic [5:0] k, input logic [7:0] b);
    logic [5:0] r;
    r = K_NONE;
    if (b == 8'h3D) begin
      case (k)
        K_ADD:    r = K_ADD_EQ;
        K_SUB:    r = K_SUB_EQ;
        K_MUL:    r = K_MUL_EQ;
        K_DIV:    r = K_DIV_EQ;
        K_MOD:    r = K_MOD_EQ;
        K_POW:    r = K_POW_EQ;
        K_ASSIGN: r = K_EQ;
        K_NOT:    r = K_NE;
        K_LT:     r = K_LE;
        K_GT:     r = K_GE;
        default:  r = K_NONE;
      endcase
    end else if (b == 8'h3E && k == K_SUB) begin
      r = K_ARROW;
    end
    return r;
  endfunction

  // Keyword compare on a prefix of up to eight bytes, byte 0 in the low bits.
  function automatic logic [5:0] keyword_kind(input logic [63:0] p, input logic [15:0] len,
                                              input int unsigned maxlen);
    logic [5:0] r;
    r = K_IDENT;
    if (len <= 16'(maxlen)) begin
      case (len)
        16'd2: begin
          if (p == 64'h6669)           r = K_IF;
          else if (p == 64'h726F)      r = K_OR;
        end
        16'd3: begin
          if (p == 64'h74656C)         r = K_LET;
          else if (p == 64'h74756D)    r = K_MUT;
          else if (p == 64'h646E61)    r = K_AND;
        end
        16'd4: begin
          if (p == 64'h636E7566)       r = K_FUNC;
          else if (p == 64'h65707974) r = K_KW_TYPE;
          else if (p == 64'h65736C65) r = K_ELSE;
          else if (p == 64'h74736163) r = K_CAST;
          else if (p == 64'h6D756E65) r = K_ENUM;
          else if (p == 64'h65757274) r = K_BOOL;
        end
        16'd5: begin
          if (p == 64'h7265666564)        r = K_DEFER;
          else if (p == 64'h656C696877)   r = K_WHILE;
          else if (p == 64'h6E6F696E75)   r = K_UNION;
          else if (p == 64'h65736C6166)   r = K_BOOL;
        end
        16'd6: begin
          if (p == 64'h6E7275746572)      r = K_RETURN;
          else if (p == 64'h666965736C65) r = K_ELSEIF;
          else if (p == 64'h746375727473) r = K_STRUCT;
          else if (p == 64'h656661736E75) r = K_UNSAFE;
        end
        default: r = K_IDENT;
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/slex_front.sv @@
// Front end: scans one byte per cycle unless q_full, giving a group of results.
module slex_front #(
  parameter int unsigned MAX_KEYWORD_LEN = slex_pkg::MaxKeywordLenDef,
  parameter int unsigned MAX_NEST        = slex_pkg::MaxNestDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              byte_take,
  input  logic              q_full,
  output logic              grp_push,
  output slex_pkg::group_t  grp_data
);

  localparam int unsigned PrefW = 8 * MAX_KEYWORD_LEN;

  slex_pkg::scan_mode_t mode_r, mode_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [15:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [15:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [15:0] tok_len_r, tok_len_nxt;
  logic [PrefW-1:0] pref_r, pref_nxt;
  logic [slex_pkg::NestW-1:0] nest_r, nest_nxt;
  logic halted_r, halted_nxt;

  slex_pkg::token_t res [3];
  logic [1:0] cnt;
  logic again;
  logic [5:0] k;
  logic [63:0] pref64;

  assign byte_take = !q_full;
  assign grp_push  = byte_valid && byte_take;
  assign pref64    = 64'(pref_r);

  always_comb begin
    mode_nxt     = mode_r;
    pend_nxt     = pend_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_len_nxt  = tok_len_r;
    pref_nxt     = pref_r;
    nest_nxt     = nest_r;
    halted_nxt   = halted_r;
    again        = 1'b0;
    cnt          = 2'd0;
    k            = slex_pkg::K_NONE;
    for (int i = 0; i < 3; i++) res[i] = '0;

    if (byte_data == 8'h00) begin
      if (!halted_r) begin
        case (mode_r)
          slex_pkg::M_UPPER:   res[0] = '{slex_pkg::K_TYPE, tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_LOWER:   res[0] = '{slex_pkg::keyword_kind(pref64, tok_len_r,
                                          MAX_KEYWORD_LEN), tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_INT:     res[0] = '{slex_pkg::K_INT, tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_FLOAT:   res[0] = '{slex_pkg::K_FLOAT, tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_FOREIGN: res[0] = '{slex_pkg::K_FOREIGN, tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_OP:      res[0] = '{pend_r, tok_line_r, tok_col_r, tok_len_r,
                                          slex_pkg::E_NONE, 1'b0};
          slex_pkg::M_BLOCK, slex_pkg::M_BHASH:
            res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                       slex_pkg::E_OPEN_BLK, 1'b0};
          slex_pkg::M_AT:      res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                                          slex_pkg::E_BAD_FGN, 1'b0};
          slex_pkg::M_STRING:  res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                                          slex_pkg::E_OPEN_STR, 1'b0};
          slex_pkg::M_CHAR:    res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                                          slex_pkg::E_BAD_CHR, 1'b0};
          default:             res[0] = '0;
        endcase
        if (mode_r != slex_pkg::M_IDLE && mode_r != slex_pkg::M_HASH &&
            mode_r != slex_pkg::M_LINE) cnt = 2'd1;
      end
      res[cnt] = '{slex_pkg::K_EOF, cur_line_r, cur_col_r, 16'd0, slex_pkg::E_NONE, 1'b1};
      cnt = cnt + 2'd1;
      // back to reset values for the next source
      mode_nxt = slex_pkg::M_IDLE; pend_nxt = '0;
      cur_line_nxt = 16'd1; cur_col_nxt = 16'd1; tok_line_nxt = 16'd1; tok_col_nxt = 16'd1;
      tok_len_nxt = '0; pref_nxt = '0; nest_nxt = '0; halted_nxt = 1'b0;
    end else begin
      if (!halted_r) begin
        case (mode_r)
          slex_pkg::M_HASH: begin
            if (byte_data == 8'h5B) begin
              mode_nxt = slex_pkg::M_BLOCK; nest_nxt = slex_pkg::NestW'(1);
            end else if (byte_data == 8'h5D) begin
              res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                         slex_pkg::E_STRAY, 1'b0};
              cnt = 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
            end else if (byte_data == 8'h0A) begin
              mode_nxt = slex_pkg::M_IDLE; again = 1'b1;
            end else begin
              mode_nxt = slex_pkg::M_LINE;
            end
          end
          slex_pkg::M_LINE: if (byte_data == 8'h0A) mode_nxt = slex_pkg::M_IDLE;
          slex_pkg::M_BLOCK: if (byte_data == 8'h23) mode_nxt = slex_pkg::M_BHASH;
          slex_pkg::M_BHASH: begin
            if (byte_data == 8'h5B) begin
              if (32'(nest_r) >= MAX_NEST) begin
                res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                           slex_pkg::E_NEST, 1'b0};
                cnt = 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
              end else begin
                nest_nxt = nest_r + 1'b1; mode_nxt = slex_pkg::M_BLOCK;
              end
            end else if (byte_data == 8'h5D) begin
              nest_nxt = (nest_r != '0) ? nest_r - 1'b1 : nest_r;
              mode_nxt = (nest_nxt == '0) ? slex_pkg::M_IDLE : slex_pkg::M_BLOCK;
            end else if (byte_data != 8'h23) begin
              mode_nxt = slex_pkg::M_BLOCK;
            end
          end
          slex_pkg::M_UPPER, slex_pkg::M_LOWER, slex_pkg::M_FOREIGN: begin
            if (slex_pkg::is_word(byte_data)) begin
              if (mode_r == slex_pkg::M_LOWER && 32'(tok_len_r) < MAX_KEYWORD_LEN)
                pref_nxt = pref_r | (PrefW'(byte_data) << (8 * tok_len_r[3:0]));
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r);
            end else begin
              case (mode_r)
                slex_pkg::M_UPPER: k = slex_pkg::K_TYPE;
                slex_pkg::M_LOWER: k = slex_pkg::keyword_kind(pref64, tok_len_r,
                                                              MAX_KEYWORD_LEN);
                default:           k = slex_pkg::K_FOREIGN;
              endcase
              res[0] = '{k, tok_line_r, tok_col_r, tok_len_r, slex_pkg::E_NONE, 1'b0};
              cnt = 2'd1; mode_nxt = slex_pkg::M_IDLE; again = 1'b1;
            end
          end
          slex_pkg::M_INT, slex_pkg::M_FLOAT: begin
            if (slex_pkg::is_digit(byte_data)) begin
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r);
            end else if (byte_data == 8'h2E && mode_r == slex_pkg::M_INT) begin
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r); mode_nxt = slex_pkg::M_FLOAT;
            end else begin
              k = (mode_r == slex_pkg::M_INT) ? slex_pkg::K_INT : slex_pkg::K_FLOAT;
              res[0] = '{k, tok_line_r, tok_col_r, tok_len_r, slex_pkg::E_NONE, 1'b0};
              cnt = 2'd1; mode_nxt = slex_pkg::M_IDLE; again = 1'b1;
            end
          end
          slex_pkg::M_OP: begin
            k = slex_pkg::pair_kind(pend_r, byte_data);
            mode_nxt = slex_pkg::M_IDLE;
            if (k != slex_pkg::K_NONE) begin
              res[0] = '{k, tok_line_r, tok_col_r, 16'd2, slex_pkg::E_NONE, 1'b0};
              tok_len_nxt = 16'd2;
            end else begin
              res[0] = '{pend_r, tok_line_r, tok_col_r, tok_len_r, slex_pkg::E_NONE, 1'b0};
              again = 1'b1;
            end
            cnt = 2'd1;
          end
          slex_pkg::M_AT: begin
            if (slex_pkg::is_lower(byte_data)) begin
              mode_nxt = slex_pkg::M_FOREIGN; tok_len_nxt = 16'd1;
            end else begin
              res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                         slex_pkg::E_BAD_FGN, 1'b0};
              cnt = 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
            end
          end
          slex_pkg::M_STRING: begin
            if (byte_data == 8'h22) begin
              res[0] = '{slex_pkg::K_STRING, tok_line_r, tok_col_r,
                         slex_pkg::sat_inc(tok_len_r), slex_pkg::E_NONE, 1'b0};
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r);
              cnt = 2'd1; mode_nxt = slex_pkg::M_IDLE;
            end else if (byte_data == 8'h0A) begin
              res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                         slex_pkg::E_OPEN_STR, 1'b0};
              cnt = 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
            end else begin
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r);
            end
          end
          slex_pkg::M_CHAR: begin
            if (byte_data == 8'h27 && tok_len_r == 16'd2) begin
              res[0] = '{slex_pkg::K_CHAR, tok_line_r, tok_col_r, 16'd3,
                         slex_pkg::E_NONE, 1'b0};
              tok_len_nxt = 16'd3; cnt = 2'd1; mode_nxt = slex_pkg::M_IDLE;
            end else if (byte_data == 8'h27 || byte_data == 8'h0A) begin
              res[0] = '{slex_pkg::K_ERROR, tok_line_r, tok_col_r, 16'd0,
                         slex_pkg::E_BAD_CHR, 1'b0};
              cnt = 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
            end else begin
              tok_len_nxt = slex_pkg::sat_inc(tok_len_r);
            end
          end
          default: begin
            mode_nxt = slex_pkg::M_IDLE; again = 1'b1;
          end
        endcase

        // classify the byte as the first of a new token
        if (again) begin
          if (byte_data == 8'h20 || byte_data == 8'h09 || byte_data == 8'h0A) begin
            mode_nxt = slex_pkg::M_IDLE;
          end else if (byte_data == 8'h23 || slex_pkg::is_upper(byte_data) ||
                       slex_pkg::is_lower(byte_data) || slex_pkg::is_digit(byte_data) ||
                       byte_data == 8'h22 || byte_data == 8'h27 || byte_data == 8'h40 ||
                       slex_pkg::op_first(byte_data) != slex_pkg::K_NONE) begin
            tok_line_nxt = cur_line_r; tok_col_nxt = cur_col_r; tok_len_nxt = 16'd1;
            if (byte_data == 8'h23) mode_nxt = slex_pkg::M_HASH;
            else if (slex_pkg::is_upper(byte_data)) mode_nxt = slex_pkg::M_UPPER;
            else if (slex_pkg::is_lower(byte_data)) begin
              mode_nxt = slex_pkg::M_LOWER; pref_nxt = PrefW'(byte_data);
            end
            else if (slex_pkg::is_digit(byte_data)) mode_nxt = slex_pkg::M_INT;
            else if (byte_data == 8'h22) mode_nxt = slex_pkg::M_STRING;
            else if (byte_data == 8'h27) mode_nxt = slex_pkg::M_CHAR;
            else if (byte_data == 8'h40) mode_nxt = slex_pkg::M_AT;
            else begin
              mode_nxt = slex_pkg::M_OP; pend_nxt = slex_pkg::op_first(byte_data);
            end
          end else if (slex_pkg::op_single(byte_data) != slex_pkg::K_NONE) begin
            res[cnt] = '{slex_pkg::op_single(byte_data), cur_line_r, cur_col_r, 16'd1,
                         slex_pkg::E_NONE, 1'b0};
            cnt = cnt + 2'd1;
          end else begin
            res[cnt] = '{slex_pkg::K_ERROR, cur_line_r, cur_col_r, 16'd0,
                         slex_pkg::E_BAD_BYTE, 1'b0};
            cnt = cnt + 2'd1; halted_nxt = 1'b1; mode_nxt = slex_pkg::M_IDLE;
          end
        end
      end
      if (byte_data == 8'h0A) begin
        cur_line_nxt = slex_pkg::sat_inc(cur_line_r); cur_col_nxt = 16'd1;
      end else begin
        cur_col_nxt = slex_pkg::sat_inc(cur_col_r);
      end
    end
  end

  assign grp_data = '{cnt, res[0], res[1], res[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slex_pkg::M_IDLE; pend_r <= '0;
      cur_line_r <= 16'd1; cur_col_r <= 16'd1; tok_line_r <= 16'd1; tok_col_r <= 16'd1;
      tok_len_r <= '0; pref_r <= '0; nest_r <= '0; halted_r <= 1'b0;
    end else if (grp_push) begin
      mode_r <= mode_nxt; pend_r <= pend_nxt;
      cur_line_r <= cur_line_nxt; cur_col_r <= cur_col_nxt;
      tok_line_r <= tok_line_nxt; tok_col_r <= tok_col_nxt;
      tok_len_r <= tok_len_nxt; pref_r <= pref_nxt; nest_r <= nest_nxt;
      halted_r <= halted_nxt;
    end
  end

  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> mode_r == slex_pkg::M_IDLE) else $error("halted while in a token");
  a_line_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cur_line_r != 16'd0 && cur_col_r != 16'd0) else $error("position fell to zero");
  a_nest_blk: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == slex_pkg::M_BLOCK || mode_r == slex_pkg::M_BHASH) |-> nest_r != '0)
    else $error("comment mode without nesting");

endmodule

@@ src/slex_back.sv @@
// Back end: group queue and serialiser that hands results out one per transaction.
module slex_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              grp_push,
  input  slex_pkg::group_t  grp_data,
  output logic              q_full,
  output logic              out_valid,
  input  logic              out_stall,
  output slex_pkg::token_t  out_tok
);

  localparam int unsigned AW = $clog2(slex_pkg::QueueDepth);

  slex_pkg::group_t mem_r [slex_pkg::QueueDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   fill_r, fill_nxt;
  logic [1:0]    sel_r;
  slex_pkg::group_t head;
  logic pop, take, wr;

  assign head   = mem_r[rp_r];
  assign q_full = fill_r == (AW+1)'(slex_pkg::QueueDepth);
  // skip groups that carry no result
  assign out_valid = fill_r != '0 && head.count != 2'd0;
  assign take   = out_valid && !out_stall;
  assign pop    = fill_r != '0 && (head.count == 2'd0 || (take && sel_r + 2'd1 == head.count));
  assign wr     = grp_push;

  always_comb begin
    case (sel_r)
      2'd0:    out_tok = head.t0;
      2'd1:    out_tok = head.t1;
      default: out_tok = head.t2;
    endcase
  end

  always_comb fill_nxt = fill_r + (AW+1)'(wr) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= grp_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; fill_r <= '0; sel_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (pop) begin
        rp_r <= rp_r + 1'b1; sel_r <= '0;
      end else if (take) begin
        sel_r <= sel_r + 2'd1;
      end
      fill_r <= fill_nxt;
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !wr) else $error("push into full queue");
  a_sel_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sel_r < head.count) else $error("result index beyond group");
  a_fill_rng: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (AW+1)'(slex_pkg::QueueDepth)) else $error("fill count out of range");

endmodule

@@ src/source_lexer.sv @@
// Top level of the streaming source lexer.
// Input channel: in_valid/in_stall with in_char_byte, one source byte per
// transaction; byte 0 ends the source and yields the end marker (out_last).
// Output channel: out_valid/out_stall with one token per transaction: kind,
// start line/column, length, error code and last flag.
// The front scanner takes one byte per cycle while the queue is not full
// and produces up to three results, which enter a four-group queue; the
// back end hands them out one per cycle while out_stall is low. Results are
// registered in the queue before they reach the output. Without stalls the
// rate is one byte per cycle while each byte yields at most one result;
// one with n results needs n transactions and the queue absorbs the excess.
// When the receiver stalls, results wait in the queue; in_stall rises once
// the queue is full. Bytes that cause no result never reach the output.
// Reset (rst_n low, synchronous) empties the queue and returns the scanner
// to line 1, column 1, outside any token.
module source_lexer #(
  parameter int unsigned MAX_KEYWORD_LEN = slex_pkg::MaxKeywordLenDef,
  parameter int unsigned MAX_NEST        = slex_pkg::MaxNestDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [15:0] out_token_length,
  output logic [2:0]  out_error_code,
  output logic        out_last
);

  logic q_full, grp_push, take;
  slex_pkg::group_t grp;
  slex_pkg::token_t tok;

  slex_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .MAX_NEST(MAX_NEST)) u_front (
    .clk, .rst_n, .byte_valid(in_valid), .byte_data(in_char_byte), .byte_take(take),
    .q_full, .grp_push, .grp_data(grp));

  slex_back u_back (
    .clk, .rst_n, .grp_push, .grp_data(grp), .q_full,
    .out_valid, .out_stall, .out_tok(tok));

  assign in_stall         = !take;
  assign out_token_kind   = tok.kind;
  assign out_start_line   = tok.line;
  assign out_start_column = tok.column;
  assign out_token_length = tok.length;
  assign out_error_code   = tok.err;
  assign out_last         = tok.last;

endmodule

@@ tb/sv/source_lexer_tb.sv @@
// Self-checking testbench for the streaming source lexer, with its own token predictor.
`timescale 1ns / 100ps

module source_lexer_tb;

  localparam int unsigned KwLen     = slex_pkg::MaxKeywordLenDef;
  localparam int unsigned NestLimit = slex_pkg::MaxNestDef;
  localparam int          CycleCap  = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_token_length;
  logic [2:0]  out_error_code;
  logic        out_last;

  source_lexer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_start_line(out_start_line),
    .out_start_column(out_start_column), .out_token_length(out_token_length),
    .out_error_code(out_error_code), .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Keyword table: the first fifteen entries carry their index as kind.
  string kw_word [19] = '{"return", "func", "let", "mut", "type", "if", "elseif", "else",
                          "cast", "defer", "while", "struct", "union", "enum", "unsafe",
                          "and", "or", "true", "false"};

  slex_pkg::token_t token_q[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          tokens_seen = 0;
  int          burst_left = 0;
  bit          hold_req = 1'b0;

  // Predictor state
  slex_pkg::scan_mode_t mode;
  logic [5:0]  pend;
  logic [15:0] cur_line, cur_col, tline, tcol, tlen;
  logic [63:0] prefix;
  int unsigned depth;
  bit          halted;

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit up_c(input logic [7:0] b); return b >= "A" && b <= "Z"; endfunction
  function automatic bit lo_c(input logic [7:0] b); return b >= "a" && b <= "z"; endfunction
  function automatic bit dig_c(input logic [7:0] b); return b >= "0" && b <= "9"; endfunction
  function automatic bit word_c(input logic [7:0] b);
    return up_c(b) || lo_c(b) || dig_c(b) || b == "_";
  endfunction

  function automatic logic [5:0] op_lead(input logic [7:0] b);
    case (b)
      "+": return slex_pkg::K_ADD;    "-": return slex_pkg::K_SUB;
      "*": return slex_pkg::K_MUL;    "/": return slex_pkg::K_DIV;
      "%": return slex_pkg::K_MOD;    "^": return slex_pkg::K_POW;
      "=": return slex_pkg::K_ASSIGN; "!": return slex_pkg::K_NOT;
      "<": return slex_pkg::K_LT;     ">": return slex_pkg::K_GT;
      default: return slex_pkg::K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] op_alone(input logic [7:0] b);
    case (b)
      ":": return slex_pkg::K_COLON;  ";": return slex_pkg::K_SEMI;
      ",": return slex_pkg::K_COMMA;  ".": return slex_pkg::K_DOT;
      "&": return slex_pkg::K_AMP;    "|": return slex_pkg::K_BAR;
      "[": return slex_pkg::K_LBRACK; "]": return slex_pkg::K_RBRACK;
      "{": return slex_pkg::K_LBRACE; "}": return slex_pkg::K_RBRACE;
      "(": return slex_pkg::K_LPAREN; ")": return slex_pkg::K_RPAREN;
      default: return slex_pkg::K_NONE;
    endcase
  endfunction

  function automatic logic [5:0] op_pair(input logic [5:0] k, input logic [7:0] b);
    if (b == "=") begin
      case (k)
        slex_pkg::K_ADD:    return slex_pkg::K_ADD_EQ;
        slex_pkg::K_SUB:    return slex_pkg::K_SUB_EQ;
        slex_pkg::K_MUL:    return slex_pkg::K_MUL_EQ;
        slex_pkg::K_DIV:    return slex_pkg::K_DIV_EQ;
        slex_pkg::K_MOD:    return slex_pkg::K_MOD_EQ;
        slex_pkg::K_POW:    return slex_pkg::K_POW_EQ;
        slex_pkg::K_ASSIGN: return slex_pkg::K_EQ;
        slex_pkg::K_NOT:    return slex_pkg::K_NE;
        slex_pkg::K_LT:     return slex_pkg::K_LE;
        slex_pkg::K_GT:     return slex_pkg::K_GE;
        default:            return slex_pkg::K_NONE;
      endcase
    end
    if (b == ">" && k == slex_pkg::K_SUB) return slex_pkg::K_ARROW;
    return slex_pkg::K_NONE;
  endfunction

  function automatic logic [5:0] word_kind(input logic [63:0] p, input logic [15:0] n);
    logic [63:0] packed_w;
    int          wl;
    if (n > KwLen) return slex_pkg::K_IDENT;
    for (int i = 0; i < 19; i++) begin
      wl = kw_word[i].len();
      if (wl != n) continue;
      packed_w = '0;
      for (int j = 0; j < wl && j < 8; j++) packed_w |= 64'(kw_word[i][j]) << (8 * j);
      if (packed_w == p) begin
        case (i)
          15: return slex_pkg::K_AND;
          16: return slex_pkg::K_OR;
          17, 18: return slex_pkg::K_BOOL;
          default: return 6'(i);
        endcase
      end
    end
    return slex_pkg::K_IDENT;
  endfunction

  task automatic lexer_clear();
    mode = slex_pkg::M_IDLE; pend = '0; cur_line = 16'd1; cur_col = 16'd1;
    tline = 16'd1; tcol = 16'd1; tlen = '0; prefix = '0; depth = 0; halted = 1'b0;
  endtask

  task automatic push_tok(input logic [5:0] k, input logic [15:0] l, input logic [15:0] c,
                          input logic [15:0] n, input logic [2:0] e, input logic lst);
    slex_pkg::token_t t;
    t.kind = k; t.line = l; t.column = c; t.length = n; t.err = e; t.last = lst;
    token_q.push_back(t);
  endtask

  task automatic raise_error(input logic [2:0] e, input logic [15:0] l, input logic [15:0] c);
    push_tok(slex_pkg::K_ERROR, l, c, 16'd0, e, 1'b0);
    halted = 1'b1;
    mode = slex_pkg::M_IDLE;
  endtask

  task automatic flush_word();
    case (mode)
      slex_pkg::M_UPPER:
        push_tok(slex_pkg::K_TYPE, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
      slex_pkg::M_LOWER:
        push_tok(word_kind(prefix, tlen), tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
      slex_pkg::M_INT:
        push_tok(slex_pkg::K_INT, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
      slex_pkg::M_FLOAT:
        push_tok(slex_pkg::K_FLOAT, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
      slex_pkg::M_FOREIGN:
        push_tok(slex_pkg::K_FOREIGN, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
      default: ;
    endcase
    mode = slex_pkg::M_IDLE;
  endtask

  task automatic open_tok(input slex_pkg::scan_mode_t m);
    mode = m; tline = cur_line; tcol = cur_col; tlen = 16'd1;
  endtask

  task automatic start_byte(input logic [7:0] b);
    logic [5:0] k;
    if (b == " " || b == "\t" || b == "\n") return;
    if (b == "#") begin open_tok(slex_pkg::M_HASH); return; end
    if (up_c(b)) begin open_tok(slex_pkg::M_UPPER); return; end
    if (lo_c(b)) begin open_tok(slex_pkg::M_LOWER); prefix = 64'(b); return; end
    if (dig_c(b)) begin open_tok(slex_pkg::M_INT); return; end
    if (b == "\"") begin open_tok(slex_pkg::M_STRING); return; end
    if (b == "'") begin open_tok(slex_pkg::M_CHAR); return; end
    if (b == "@") begin open_tok(slex_pkg::M_AT); return; end
    k = op_lead(b);
    if (k != slex_pkg::K_NONE) begin open_tok(slex_pkg::M_OP); pend = k; return; end
    k = op_alone(b);
    if (k != slex_pkg::K_NONE) begin
      push_tok(k, cur_line, cur_col, 16'd1, slex_pkg::E_NONE, 1'b0);
      return;
    end
    raise_error(slex_pkg::E_BAD_BYTE, cur_line, cur_col);
  endtask

  // Work out the tokens that one accepted byte produces.
  task automatic lex_byte(input logic [7:0] b);
    logic [5:0] k;
    bit         again;
    again = 1'b0;
    if (b == 8'h00) begin
      if (!halted) begin
        case (mode)
          slex_pkg::M_UPPER, slex_pkg::M_LOWER, slex_pkg::M_INT, slex_pkg::M_FLOAT,
          slex_pkg::M_FOREIGN: flush_word();
          slex_pkg::M_OP: push_tok(pend, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
          slex_pkg::M_BLOCK, slex_pkg::M_BHASH:
            raise_error(slex_pkg::E_OPEN_BLK, tline, tcol);
          slex_pkg::M_AT:     raise_error(slex_pkg::E_BAD_FGN, tline, tcol);
          slex_pkg::M_STRING: raise_error(slex_pkg::E_OPEN_STR, tline, tcol);
          slex_pkg::M_CHAR:   raise_error(slex_pkg::E_BAD_CHR, tline, tcol);
          default: ;
        endcase
      end
      push_tok(slex_pkg::K_EOF, cur_line, cur_col, 16'd0, slex_pkg::E_NONE, 1'b1);
      lexer_clear();
      return;
    end
    if (!halted) begin
      case (mode)
        slex_pkg::M_HASH: begin
          if (b == "[") begin mode = slex_pkg::M_BLOCK; depth = 1; end
          else if (b == "]") raise_error(slex_pkg::E_STRAY, tline, tcol);
          else if (b == "\n") begin mode = slex_pkg::M_IDLE; again = 1'b1; end
          else mode = slex_pkg::M_LINE;
        end
        slex_pkg::M_LINE: if (b == "\n") mode = slex_pkg::M_IDLE;
        slex_pkg::M_BLOCK: if (b == "#") mode = slex_pkg::M_BHASH;
        slex_pkg::M_BHASH: begin
          if (b == "[") begin
            if (depth >= NestLimit) raise_error(slex_pkg::E_NEST, tline, tcol);
            else begin depth++; mode = slex_pkg::M_BLOCK; end
          end else if (b == "]") begin
            if (depth > 0) depth--;
            mode = (depth == 0) ? slex_pkg::M_IDLE : slex_pkg::M_BLOCK;
          end else if (b != "#") begin
            mode = slex_pkg::M_BLOCK;
          end
        end
        slex_pkg::M_UPPER, slex_pkg::M_LOWER, slex_pkg::M_FOREIGN: begin
          if (word_c(b)) begin
            if (mode == slex_pkg::M_LOWER && tlen < KwLen && tlen < 8)
              prefix |= 64'(b) << (8 * tlen);
            tlen = bump16(tlen);
          end else begin flush_word(); again = 1'b1; end
        end
        slex_pkg::M_INT: begin
          if (dig_c(b)) tlen = bump16(tlen);
          else if (b == ".") begin tlen = bump16(tlen); mode = slex_pkg::M_FLOAT; end
          else begin flush_word(); again = 1'b1; end
        end
        slex_pkg::M_FLOAT: begin
          if (dig_c(b)) tlen = bump16(tlen);
          else begin flush_word(); again = 1'b1; end
        end
        slex_pkg::M_OP: begin
          k = op_pair(pend, b);
          if (k != slex_pkg::K_NONE) begin
            tlen = 16'd2;
            push_tok(k, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
          end else begin
            push_tok(pend, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
            again = 1'b1;
          end
          mode = slex_pkg::M_IDLE;
        end
        slex_pkg::M_AT: begin
          if (lo_c(b)) begin mode = slex_pkg::M_FOREIGN; tlen = 16'd1; end
          else raise_error(slex_pkg::E_BAD_FGN, tline, tcol);
        end
        slex_pkg::M_STRING: begin
          if (b == "\"") begin
            tlen = bump16(tlen);
            push_tok(slex_pkg::K_STRING, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
            mode = slex_pkg::M_IDLE;
          end else if (b == "\n") raise_error(slex_pkg::E_OPEN_STR, tline, tcol);
          else tlen = bump16(tlen);
        end
        slex_pkg::M_CHAR: begin
          if (b == "'") begin
            if (tlen == 16'd2) begin
              tlen = 16'd3;
              push_tok(slex_pkg::K_CHAR, tline, tcol, tlen, slex_pkg::E_NONE, 1'b0);
              mode = slex_pkg::M_IDLE;
            end else raise_error(slex_pkg::E_BAD_CHR, tline, tcol);
          end else if (b == "\n") raise_error(slex_pkg::E_BAD_CHR, tline, tcol);
          else tlen = bump16(tlen);
        end
        default: begin
          mode = slex_pkg::M_IDLE;
          again = 1'b1;
        end
      endcase
      if (again && !halted) start_byte(b);
    end
    if (b == "\n") begin cur_line = bump16(cur_line); cur_col = 16'd1; end
    else cur_col = bump16(cur_col);
  endtask

  // Offer one byte; gaps fall between bursts of random length.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_char_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_byte(b);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_keywords();
    send_text("func defer elseif returns or Ab_9\n");
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_operators();
    send_text("a+=b->c!=d<=e>=f==g-h:.;");
    send_byte(8'h00);
    drain();
    send_text("x>");
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_literals();
    send_text("42 3.14 7. \"hi\" 'c' @ext(x) #n\n#[a#[b#]#]z");
    send_byte(8'h00);
    drain();
  endtask

  task automatic test_errors();
    // each source halts at the first fatal error; later bytes stay silent up to its end marker
    send_text("a #] b"); send_byte(8'h00);
    send_text("#[ x"); send_byte(8'h00);
    send_text("\"ab\nc"); send_byte(8'h00);
    send_text("\"o"); send_byte(8'h00);
    send_text("'ab'"); send_byte(8'h00);
    send_text("@9"); send_byte(8'h00);
    send_text("_x"); send_byte(8'h00);
    send_text("k "); send_byte(8'h80); send_byte(8'h01); send_byte(8'h00);
    drain();
  endtask

  // Hold the receiver off while single-byte tokens pour in.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (5) send_text(";(");
    send_byte(8'h00);
    drain();
  endtask

  task automatic send_random_token();
    int         c;
    logic [7:0] ch;
    string      singles;
    string      leads;
    singles = ":;,.&|[]{}()";
    leads = "+-*/%^=!<>";
    c = $urandom_range(0, 99);
    if (c < 15) send_text(kw_word[$urandom_range(0, 18)]);
    else if (c < 30) begin
      send_byte(c < 23 ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z")));
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 3))
          0: send_byte(8'($urandom_range("a", "z")));
          1: send_byte(8'($urandom_range("A", "Z")));
          2: send_byte(8'($urandom_range("0", "9")));
          default: send_byte("_");
        endcase
      end
    end else if (c < 40) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range("0", "9")));
      if (c < 35) begin
        send_byte(".");
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range("0", "9")));
      end
    end else if (c < 46) begin
      send_byte("\"");
      repeat ($urandom_range(0, 4)) begin
        ch = 8'($urandom_range(32, 126));
        if (ch == "\"") ch = "x";
        send_byte(ch);
      end
      send_byte("\"");
    end else if (c < 50) begin
      send_byte("'"); send_byte(8'($urandom_range("!", "~"))); send_byte("'");
    end else if (c < 54) begin
      send_byte("@"); send_byte(8'($urandom_range("a", "z")));
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range("a", "z")));
    end else if (c < 76) begin
      if ($urandom_range(0, 1)) send_byte(singles[$urandom_range(0, 11)]);
      else send_byte(leads[$urandom_range(0, 9)]);
      if ($urandom_range(0, 2) == 0) send_byte($urandom_range(0, 3) == 0 ? ">" : "=");
    end else if (c < 82) begin
      send_text("# c\n");
    end else if (c < 88) begin
      send_text("#[ x ");
      if ($urandom_range(0, 1)) send_text("#[ y #] ");
      send_text("#]");
    end else if (c < 95) begin
      send_byte("\n");
    end else begin
      send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_random();
    int goal;
    goal = bytes_sent + 15;
    while (bytes_sent < goal) begin
      repeat ($urandom_range(1, 3)) begin
        send_random_token();
        case ($urandom_range(0, 3))
          0: send_byte(" ");
          1: send_byte("\t");
          2: send_byte("\n");
          default: ;
        endcase
      end
      send_byte(8'h00);
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
  endtask

  // Receiver stall pattern: each phase picks a stall share of 0, 25 or 70 percent.
  initial begin
    int phase_left;
    int stall_pct;
    phase_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = 64;
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 70;
          endcase
        end
        phase_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      slex_pkg::token_t t;
      tokens_seen++;
      if (token_q.size() == 0) begin
        $error("token with nothing expected: kind %0d", out_token_kind);
        fail_count++;
      end else begin
        t = token_q.pop_front();
        if (out_token_kind !== t.kind) begin
          $error("token_kind: expected %0d, got %0d", t.kind, out_token_kind); fail_count++;
        end
        if (out_start_line !== t.line) begin
          $error("start_line: expected %0d, got %0d", t.line, out_start_line); fail_count++;
        end
        if (out_start_column !== t.column) begin
          $error("start_column: expected %0d, got %0d", t.column, out_start_column);
          fail_count++;
        end
        if (out_token_length !== t.length) begin
          $error("token_length: expected %0d, got %0d", t.length, out_token_length);
          fail_count++;
        end
        if (out_error_code !== t.err) begin
          $error("error_code: expected %0d, got %0d", t.err, out_error_code); fail_count++;
        end
        if (out_last !== t.last) begin
          $error("last: expected %0d, got %0d", t.last, out_last); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    lexer_clear();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_keywords();
    test_operators();
    test_literals();
    test_errors();
    test_backpressure();
    test_random();
    drain();
    if (token_q.size() != 0) begin
      $error("%0d expected tokens never arrived", token_q.size());
      fail_count++;
    end
    $display("Covered keywords, operators, literals, comments, the error codes short of");
    $display("nesting overflow, back-pressure and random sources: %0d bytes in, %0d tokens out.",
             bytes_sent, tokens_seen);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
